@@ hdl/tcs_pkg.sv @@
package tcs_pkg;

  // Screen geometry
  localparam int NUM_COLS   = 80;
  localparam int NUM_ROWS   = 25;
  localparam int CELL_COUNT = NUM_COLS * NUM_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(NUM_COLS);
  localparam int ROW_W      = $clog2(NUM_ROWS);
  localparam int POS_W      = 11;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [15:0]       cell_t;
  typedef logic [7:0]        byte_t;
  typedef logic [1:0]        cmd_t;

  // Command codes
  localparam cmd_t CMD_PUT   = 2'd0;
  localparam cmd_t CMD_CLEAR = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  // Control characters and fill words
  localparam byte_t CHAR_NL     = 8'h0A;
  localparam byte_t CHAR_CR     = 8'h0D;
  localparam byte_t CHAR_BS     = 8'h08;
  localparam byte_t CHAR_BLANK  = 8'h20;
  localparam byte_t ATTR_RESET  = 8'h0F;
  localparam cell_t RESET_FILL  = 16'h0F20;
  localparam cell_t SCROLL_FILL = 16'h0720;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_BOTTOM,
    ST_EMIT
  } state_t;

  // Source of the cell store write port
  typedef enum logic [2:0] {
    WSRC_NONE,
    WSRC_PUT,
    WSRC_RESET,
    WSRC_CLEAR,
    WSRC_COPY,
    WSRC_SCROLL
  } wsrc_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  item_load;
    logic  cur_put;
    logic  cur_home;
    logic  sweep_clr;
    logic  sweep_inc;
    logic  rd_cell;
    logic  rd_copy;
    logic  emit;
    wsrc_t wsrc;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t item_cmd;
    logic put_scroll;
    logic sweep_end;
    logic copy_end;
    logic out_free;
  } sts_t;

  function automatic addr_t cell_addr(row_t row, col_t col);
    cell_addr = addr_t'(32'(row) * NUM_COLS + 32'(col));
  endfunction

  function automatic pos_t cursor_pos(row_t row, col_t col);
    cursor_pos = pos_t'(32'(row) * NUM_COLS + 32'(col));
  endfunction

endpackage

@@ hdl/tcs_if.sv @@
interface tcs_in_if;
  logic             valid;
  logic             ready;
  tcs_pkg::cmd_t    cmd;
  tcs_pkg::byte_t   char_code;
  tcs_pkg::byte_t   clear_attr;
  logic [10:0]      cell_index;

  modport source (output valid, cmd, char_code, clear_attr, cell_index, input ready);
  modport sink   (input valid, cmd, char_code, clear_attr, cell_index, output ready);
endinterface

interface tcs_out_if;
  logic             valid;
  logic             ready;
  tcs_pkg::pos_t    cursor_pos;
  tcs_pkg::cell_t   cell_value;

  modport source (output valid, cursor_pos, cell_value, input ready);
  modport sink   (input valid, cursor_pos, cell_value, output ready);
endinterface

@@ hdl/tcs_ram.sv @@
module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/tcs_dp.sv @@
module tcs_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  tcs_pkg::ctl_t   ctl,
  output tcs_pkg::sts_t   sts,
  input  tcs_pkg::cmd_t   in_cmd,
  input  tcs_pkg::byte_t  in_char_code,
  input  tcs_pkg::byte_t  in_clear_attr,
  input  logic [10:0]     in_cell_index,
  input  logic            cfg_wr_en,
  input  tcs_pkg::byte_t  cfg_wr_data,
  input  logic            out_ready,
  output logic            out_valid,
  output tcs_pkg::pos_t   out_cursor_pos,
  output tcs_pkg::cell_t  out_cell_value
);

  // Latched transaction
  tcs_pkg::cmd_t  item_cmd_r;
  tcs_pkg::byte_t item_char_r;
  tcs_pkg::byte_t item_attr_r;
  logic [10:0]    item_idx_r;

  tcs_pkg::byte_t text_attr_r;
  tcs_pkg::row_t  row_r;
  tcs_pkg::col_t  col_r;
  tcs_pkg::addr_t sweep_r;

  logic           out_valid_r;
  tcs_pkg::pos_t  out_pos_r;
  tcs_pkg::cell_t out_val_r;

  // Cursor update for a put
  logic               is_nl, is_cr, is_bs;
  logic [tcs_pkg::COL_W:0] col_a;
  logic [tcs_pkg::ROW_W:0] row_a, row_b;
  logic               col_wrap;
  tcs_pkg::col_t      col_nxt;
  tcs_pkg::row_t      row_nxt;
  tcs_pkg::col_t      put_col;
  logic               put_we;
  tcs_pkg::cell_t     put_word;

  // Store ports
  logic           mem_we;
  tcs_pkg::addr_t mem_waddr;
  tcs_pkg::cell_t mem_wdata;
  logic           mem_re;
  tcs_pkg::addr_t mem_raddr;
  tcs_pkg::cell_t mem_rdata;
  logic           idx_in_range;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      item_cmd_r  <= in_cmd;
      item_char_r <= in_char_code;
      item_attr_r <= in_clear_attr;
      item_idx_r  <= in_cell_index;
    end
  end

  // Attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= tcs_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      text_attr_r <= cfg_wr_data;
    end
  end

  // Decode the put character and work out the new cursor
  always_comb begin
    is_nl = (item_char_r == tcs_pkg::CHAR_NL);
    is_cr = (item_char_r == tcs_pkg::CHAR_CR);
    is_bs = (item_char_r == tcs_pkg::CHAR_BS);
    row_a = {1'b0, row_r};
    if (is_nl) begin
      col_a = '0;
      row_a = {1'b0, row_r} + 1'b1;
    end else if (is_cr) begin
      col_a = '0;
    end else if (is_bs) begin
      col_a = (col_r != '0) ? {1'b0, col_r} - 1'b1 : {1'b0, col_r};
    end else begin
      col_a = {1'b0, col_r} + 1'b1;
    end
    col_wrap = (32'(col_a) >= tcs_pkg::NUM_COLS);
    col_nxt  = col_wrap ? '0 : tcs_pkg::col_t'(col_a);
    row_b    = row_a + {{tcs_pkg::ROW_W{1'b0}}, col_wrap};
    row_nxt  = (32'(row_b) >= tcs_pkg::NUM_ROWS) ? tcs_pkg::row_t'(tcs_pkg::NUM_ROWS - 1)
                                                 : tcs_pkg::row_t'(row_b);
    put_we   = !is_nl && !is_cr;
    put_col  = is_bs ? tcs_pkg::col_t'(col_a) : col_r;
    put_word = {text_attr_r, is_bs ? tcs_pkg::CHAR_BLANK : item_char_r};
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (ctl.cur_home) begin
      row_r <= '0;
      col_r <= '0;
    end else if (ctl.cur_put) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Sweep counter for reset pass, clear and scroll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (ctl.sweep_clr) begin
      sweep_r <= '0;
    end else if (ctl.sweep_inc) begin
      sweep_r <= sweep_r + 1'b1;
    end
  end

  // Write port select
  always_comb begin
    mem_we    = 1'b1;
    mem_waddr = sweep_r;
    mem_wdata = tcs_pkg::RESET_FILL;
    case (ctl.wsrc)
      tcs_pkg::WSRC_PUT: begin
        mem_we    = put_we;
        mem_waddr = tcs_pkg::cell_addr(row_r, put_col);
        mem_wdata = put_word;
      end
      tcs_pkg::WSRC_RESET:  mem_wdata = tcs_pkg::RESET_FILL;
      tcs_pkg::WSRC_CLEAR:  mem_wdata = {item_attr_r, tcs_pkg::CHAR_BLANK};
      tcs_pkg::WSRC_COPY:   mem_wdata = mem_rdata;
      tcs_pkg::WSRC_SCROLL: mem_wdata = tcs_pkg::SCROLL_FILL;
      default:              mem_we    = 1'b0;
    endcase
  end

  // Read port select: one cell for a read, the row below for a scroll
  assign mem_re    = ctl.rd_cell || ctl.rd_copy;
  assign mem_raddr = ctl.rd_copy ? tcs_pkg::addr_t'(32'(sweep_r) + tcs_pkg::NUM_COLS)
                                 : tcs_pkg::addr_t'(item_idx_r);

  tcs_ram #(
    .WIDTH ($bits(tcs_pkg::cell_t)),
    .DEPTH (tcs_pkg::CELL_COUNT)
  ) u_cells (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign idx_in_range = (32'(item_idx_r) < tcs_pkg::CELL_COUNT);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_pos_r <= tcs_pkg::cursor_pos(row_r, col_r);
      out_val_r <= (item_cmd_r == tcs_pkg::CMD_READ && idx_in_range) ? mem_rdata : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_value = out_val_r;

  // Status to the controller
  always_comb begin
    sts.item_cmd   = item_cmd_r;
    sts.put_scroll = (32'(row_b) >= tcs_pkg::NUM_ROWS);
    sts.sweep_end  = (32'(sweep_r) == tcs_pkg::CELL_COUNT - 1);
    sts.copy_end   = (32'(sweep_r) == tcs_pkg::CELL_COUNT - tcs_pkg::NUM_COLS - 1);
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

@@ hdl/tcs_ctrl.sv @@
module tcs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcs_pkg::sts_t sts,
  output tcs_pkg::ctl_t ctl
);

  tcs_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcs_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ctl       = '0;
    ctl.wsrc  = tcs_pkg::WSRC_NONE;
    unique case (state_r)
      tcs_pkg::ST_INIT: begin
        ctl.wsrc = tcs_pkg::WSRC_RESET;
        if (sts.sweep_end) begin
          ctl.sweep_clr = 1'b1;
          state_nxt     = tcs_pkg::ST_IDLE;
        end else begin
          ctl.sweep_inc = 1'b1;
        end
      end
      tcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.item_load = 1'b1;
          state_nxt     = tcs_pkg::ST_EXEC;
        end
      end
      tcs_pkg::ST_EXEC: begin
        unique case (sts.item_cmd)
          tcs_pkg::CMD_PUT: begin
            ctl.wsrc    = tcs_pkg::WSRC_PUT;
            ctl.cur_put = 1'b1;
            state_nxt   = sts.put_scroll ? tcs_pkg::ST_SCR_RD : tcs_pkg::ST_EMIT;
          end
          tcs_pkg::CMD_CLEAR: state_nxt = tcs_pkg::ST_FILL;
          tcs_pkg::CMD_READ: begin
            ctl.rd_cell = 1'b1;
            state_nxt   = tcs_pkg::ST_EMIT;
          end
          default: state_nxt = tcs_pkg::ST_EMIT;
        endcase
      end
      tcs_pkg::ST_FILL: begin
        ctl.wsrc = tcs_pkg::WSRC_CLEAR;
        if (sts.sweep_end) begin
          ctl.sweep_clr = 1'b1;
          ctl.cur_home  = 1'b1;
          state_nxt     = tcs_pkg::ST_EMIT;
        end else begin
          ctl.sweep_inc = 1'b1;
        end
      end
      tcs_pkg::ST_SCR_RD: begin
        ctl.rd_copy = 1'b1;
        state_nxt   = tcs_pkg::ST_SCR_WR;
      end
      tcs_pkg::ST_SCR_WR: begin
        ctl.wsrc      = tcs_pkg::WSRC_COPY;
        ctl.sweep_inc = 1'b1;
        state_nxt     = sts.copy_end ? tcs_pkg::ST_BOTTOM : tcs_pkg::ST_SCR_RD;
      end
      tcs_pkg::ST_BOTTOM: begin
        ctl.wsrc = tcs_pkg::WSRC_SCROLL;
        if (sts.sweep_end) begin
          ctl.sweep_clr = 1'b1;
          state_nxt     = tcs_pkg::ST_EMIT;
        end else begin
          ctl.sweep_inc = 1'b1;
        end
      end
      tcs_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = tcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcs_pkg::ST_INIT;
    endcase
  end

endmodule

@@ hdl/text_console_cursor_scroll.sv @@
// Channel   Dir  Handshake           Payload
// in_ch     in   valid/ready         cmd, char_code, clear_attr, cell_index
// out_ch    out  valid/ready         cursor_pos, cell_value
// cfg       in   cfg_wr_en           cfg_wr_data (text attribute)
//
// Put, read and unused commands pass through accept, execute and result load.
// A put that scrolls copies every row below the top one row up, a read then a write
// per cell through the single read and single write port of the cell store, then
// fills the bottom row with SCROLL_FILL. Clear writes every cell, one cell written per cycle.
// After reset a clearing pass over every cell runs before in_ch.ready rises.
// A finished result waits in the output register; the next transaction is taken
// meanwhile and stalls only when its own result is due.
module text_console_cursor_scroll (
  input  logic           clk,
  input  logic           rst_n,
  tcs_in_if.sink         in_ch,
  tcs_out_if.source      out_ch,
  input  logic           cfg_wr_en,
  input  tcs_pkg::byte_t cfg_wr_data
);

  tcs_pkg::ctl_t ctl;
  tcs_pkg::sts_t sts;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tcs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_cmd         (in_ch.cmd),
    .in_char_code   (in_ch.char_code),
    .in_clear_attr  (in_ch.clear_attr),
    .in_cell_index  (in_ch.cell_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_cursor_pos (out_ch.cursor_pos),
    .out_cell_value (out_ch.cell_value)
  );

endmodule

@@ hdl/tcs_chk.sv @@
module tcs_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tcs_pkg::pos_t  out_cursor_pos,
  input tcs_pkg::cell_t out_cell_value
);

  // Result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cursor_pos) && $stable(out_cell_value))
    else $error("stalled result changed");

  // Cursor always reported inside the screen
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_pos) < tcs_pkg::CELL_COUNT))
    else $error("cursor position outside the screen");

  // Clearing pass follows reset, so no transaction is taken right after it
  a_init_pass: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

endmodule

bind text_console_cursor_scroll tcs_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_cursor_pos (out_ch.cursor_pos),
  .out_cell_value (out_ch.cell_value)
);
